[sv/mrh_pkg.sv]
// ----------------------------------------------------------------------------
// mrh_pkg
// Shared types and codes for the monotone radix heap.
// ----------------------------------------------------------------------------
package mrh_pkg;

  localparam int ORD_W = 32;
  localparam int OCC_W = 11;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_LOW   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_ALLOC,
    S_PUSH_WR,
    S_RN_OUTER,
    S_RN_LATCH,
    S_RN_INNER,
    S_RN_COPY,
    S_POP_SCAN,
    S_POP_REB,
    S_POP_REMOVE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic lex_lt;
    logic ord_gt;
  } cmp_res_t;

endpackage

[sv/mrh_ram.sv]
// ----------------------------------------------------------------------------
// mrh_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/mrh_cmp.sv]
// ----------------------------------------------------------------------------
// mrh_cmp
// Shared compare unit: (bucket, key, value) ordering, order-stamp compare
// and bucket number of a key against the last popped key.
// ----------------------------------------------------------------------------
module mrh_cmp
  import mrh_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  parameter int BKT_W      = 6
) (
  input  logic [BKT_W-1:0]      cand_bucket,
  input  logic [KEY_BITS-1:0]   cand_key,
  input  logic [VALUE_BITS-1:0] cand_value,
  input  logic [BKT_W-1:0]      best_bucket,
  input  logic [KEY_BITS-1:0]   best_key,
  input  logic [VALUE_BITS-1:0] best_value,
  input  logic [ORD_W-1:0]      ord_a,
  input  logic [ORD_W-1:0]      ord_b,
  input  logic [KEY_BITS-1:0]   base_key,
  output cmp_res_t              res,
  output logic [BKT_W-1:0]      new_bucket
);

  logic [KEY_BITS-1:0] diff;

  assign diff = cand_key ^ base_key;
  assign res.lex_lt = {cand_bucket, cand_key, cand_value} <
                      {best_bucket, best_key, best_value};
  assign res.ord_gt = ord_a > ord_b;

  // bit length of the key difference
  always_comb begin
    new_bucket = '0;
    for (int i = 0; i < KEY_BITS; i++) begin
      if (diff[i]) begin
        new_bucket = BKT_W'(i + 1);
      end
    end
  end

endmodule

[sv/monotone_radix_heap.sv]
// ----------------------------------------------------------------------------
// monotone_radix_heap
// Monotone min-priority queue of key/value pairs kept in radix buckets.
// ----------------------------------------------------------------------------
// One word at a time. A push allocates a slot, writes it, then loads its result.
// A pop streams over the used slot range (H = highest slot count ever used)
// through the single read port of the slot memories: one scan pass when bucket 0
// holds an entry, a second pass when the lowest bucket must first be re-bucketed,
// then removal and the result. When the order-stamp counter reaches 2^32-1 the
// stamps are renumbered before a push, using the one shared stamp comparator.
// No clearing pass after reset. Results sit in an output register.
module monotone_radix_heap
  import mrh_pkg::*;
#(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  parameter int CAPACITY   = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic                  cmd,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [KEY_BITS-1:0]   out_key,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [1:0]            status,
  output logic [OCC_W-1:0]      occupancy
);

  localparam int BKT_W  = $clog2(KEY_BITS + 1);
  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int META_W = BKT_W + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t state, state_next;

  logic [KEY_BITS-1:0]   p_key, last_key, mk, b0_key, r_key;
  logic [VALUE_BITS-1:0] p_val, mv, b0_val, r_val;
  status_t               r_status;
  logic [CNT_W-1:0]      cnt, fcnt, hwm, sa, ri, rcnt;
  logic [CNT_W-1:0]      fcnt_m1;
  logic [ORD_W-1:0]      ord_ctr, b0_ord, ref_ord;
  logic [IDX_W-1:0]      sidx, b0_idx;
  logic [BKT_W-1:0]      mb, bi;
  logic                  sv, fnd, f0, use_free;

  // memory ports
  logic [IDX_W-1:0]      rd_addr, slot;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_val;
  logic [META_W-1:0]     q_meta, meta_wdata;
  logic [ORD_W-1:0]      q_order, ord_wdata;
  logic [IDX_W-1:0]      q_free, q_tmp;
  logic                  kv_we, meta_we, ord_we, free_we, tmp_we;
  logic [IDX_W-1:0]      meta_waddr, ord_waddr;
  logic                  q_valid;
  logic [BKT_W-1:0]      q_bucket;

  // shared unit
  cmp_res_t              cres;
  logic [BKT_W-1:0]      nb;
  logic [KEY_BITS-1:0]   cand_key;
  logic [ORD_W-1:0]      ord_a, ord_b;

  logic scanning, scan_issue, scan_done, hit, rsp_load;
  logic [OCC_W+CNT_W-1:0] occ_ext;

  assign q_valid  = q_meta[META_W-1];
  assign q_bucket = q_meta[BKT_W-1:0];
  assign fcnt_m1  = fcnt - CNT_W'(1);
  assign slot     = use_free ? q_free : hwm[IDX_W-1:0];
  assign scanning = (state == S_RN_INNER) || (state == S_RN_COPY) ||
                    (state == S_POP_SCAN) || (state == S_POP_REB);
  assign scan_issue = sa < hwm;
  assign scan_done  = !scan_issue && !sv;
  assign hit        = sv && q_valid;
  assign cmd_ready  = (state == S_IDLE);
  assign rsp_load   = (state == S_RESP) && (!rsp_valid || rsp_ready);
  assign occ_ext    = {{OCC_W{1'b0}}, cnt};

  mrh_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(kv_we), .waddr(slot), .wdata(p_key),
    .raddr(rd_addr), .rdata(q_key)
  );

  mrh_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk(clk), .we(kv_we), .waddr(slot), .wdata(p_val),
    .raddr(rd_addr), .rdata(q_val)
  );

  mrh_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta_ram (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(rd_addr), .rdata(q_meta)
  );

  mrh_ram #(.WIDTH(ORD_W), .DEPTH(CAPACITY)) u_ord_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
    .raddr(rd_addr), .rdata(q_order)
  );

  // stack of freed slots
  mrh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(fcnt[IDX_W-1:0]), .wdata(b0_idx),
    .raddr(fcnt_m1[IDX_W-1:0]), .rdata(q_free)
  );

  // ranks while renumbering order stamps
  mrh_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_tmp_ram (
    .clk(clk), .we(tmp_we), .waddr(ri[IDX_W-1:0]), .wdata(rcnt[IDX_W-1:0]),
    .raddr(sa[IDX_W-1:0]), .rdata(q_tmp)
  );

  mrh_cmp #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .BKT_W(BKT_W)) u_cmp (
    .cand_bucket(q_bucket), .cand_key(cand_key), .cand_value(q_val),
    .best_bucket(mb), .best_key(mk), .best_value(mv),
    .ord_a(ord_a), .ord_b(ord_b), .base_key(last_key),
    .res(cres), .new_bucket(nb)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd == CMD_POP) begin
            state_next = (cnt == '0) ? S_RESP : S_POP_SCAN;
          end else if (cnt >= CAP_CNT || key < last_key) begin
            state_next = S_RESP;
          end else if (ord_ctr == '1) begin
            state_next = S_RN_OUTER;
          end else begin
            state_next = S_PUSH_ALLOC;
          end
        end
      end
      S_PUSH_ALLOC: state_next = S_PUSH_WR;
      S_PUSH_WR:    state_next = S_RESP;
      S_RN_OUTER:   state_next = (ri < hwm) ? S_RN_LATCH : S_RN_COPY;
      S_RN_LATCH:   state_next = q_valid ? S_RN_INNER : S_RN_OUTER;
      S_RN_INNER:   if (scan_done) state_next = S_RN_OUTER;
      S_RN_COPY:    if (scan_done) state_next = S_PUSH_ALLOC;
      S_POP_SCAN: begin
        if (scan_done) begin
          state_next = (mb == '0) ? S_POP_REMOVE : S_POP_REB;
        end
      end
      S_POP_REB:    if (scan_done) state_next = S_POP_REMOVE;
      S_POP_REMOVE: state_next = S_RESP;
      S_RESP:       if (rsp_load) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // memory and compare-unit controls
  always_comb begin
    rd_addr    = scanning ? sa[IDX_W-1:0] : ri[IDX_W-1:0];
    kv_we      = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = sidx;
    meta_wdata = {1'b1, nb};
    ord_we     = 1'b0;
    ord_waddr  = slot;
    ord_wdata  = ord_ctr;
    free_we    = 1'b0;
    tmp_we     = 1'b0;
    cand_key   = q_key;
    ord_a      = q_order;
    ord_b      = b0_ord;
    case (state)
      S_PUSH_WR: begin
        cand_key   = p_key;
        kv_we      = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = slot;
        ord_we     = 1'b1;
      end
      S_RN_INNER: begin
        ord_a  = ref_ord;
        ord_b  = q_order;
        tmp_we = scan_done;
      end
      S_RN_COPY: begin
        ord_we    = hit;
        ord_waddr = sidx;
        ord_wdata = {{(ORD_W - IDX_W){1'b0}}, q_tmp};
      end
      S_POP_REB: begin
        meta_we = hit && (q_bucket == bi);
      end
      S_POP_REMOVE: begin
        meta_we    = 1'b1;
        meta_waddr = b0_idx;
        meta_wdata = '0;
        free_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_key  <= '0;
      cnt       <= '0;
      fcnt      <= '0;
      hwm       <= '0;
      ord_ctr   <= '0;
      sa        <= '0;
      sv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (scanning) begin
        if (scan_issue) begin
          sa   <= sa + CNT_W'(1);
          sidx <= sa[IDX_W-1:0];
        end
        sv <= scan_issue;
        if (scan_done) begin
          sa <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          p_key <= key;
          p_val <= value;
          r_key <= '0;
          r_val <= '0;
          fnd   <= 1'b0;
          f0    <= 1'b0;
          ri    <= '0;
          if (cmd == CMD_POP) begin
            r_status <= ST_EMPTY;
          end else if (cnt >= CAP_CNT) begin
            r_status <= ST_FULL;
          end else begin
            r_status <= ST_LOW;
          end
        end
        S_PUSH_ALLOC: begin
          use_free <= (fcnt != '0);
        end
        S_PUSH_WR: begin
          // free stack pops together with the count update
          if (use_free) begin
            fcnt <= fcnt_m1;
          end else begin
            hwm <= hwm + CNT_W'(1);
          end
          ord_ctr  <= ord_ctr + ORD_W'(1);
          cnt      <= cnt + CNT_W'(1);
          r_status <= ST_OK;
        end
        S_RN_LATCH: begin
          ref_ord <= q_order;
          rcnt    <= '0;
          if (!q_valid) begin
            ri <= ri + CNT_W'(1);
          end
        end
        S_RN_INNER: begin
          if (hit && cres.ord_gt) begin
            rcnt <= rcnt + CNT_W'(1);
          end
          if (scan_done) begin
            ri <= ri + CNT_W'(1);
          end
        end
        S_RN_COPY: begin
          if (scan_done) begin
            ord_ctr <= {{(ORD_W - CNT_W){1'b0}}, cnt};
          end
        end
        S_POP_SCAN: begin
          if (hit && (!fnd || cres.lex_lt)) begin
            fnd <= 1'b1;
            mb  <= q_bucket;
            mk  <= q_key;
            mv  <= q_val;
          end
          if (hit && q_bucket == '0 && (!f0 || cres.ord_gt)) begin
            f0     <= 1'b1;
            b0_idx <= sidx;
            b0_key <= q_key;
            b0_val <= q_val;
            b0_ord <= q_order;
          end
          if (scan_done && mb != '0) begin
            last_key <= mk;
            bi       <= mb;
          end
        end
        S_POP_REB: begin
          // entries landing in bucket 0 are exactly those equal to the new last key
          if (hit && q_bucket == bi && nb == '0 && (!f0 || cres.ord_gt)) begin
            f0     <= 1'b1;
            b0_idx <= sidx;
            b0_key <= q_key;
            b0_val <= q_val;
            b0_ord <= q_order;
          end
        end
        S_POP_REMOVE: begin
          fcnt     <= fcnt + CNT_W'(1);
          cnt      <= cnt - CNT_W'(1);
          r_key    <= b0_key;
          r_val    <= b0_val;
          r_status <= ST_OK;
        end
        default: begin
        end
      endcase

      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_key   <= r_key;
      out_value <= r_val;
      status    <= r_status;
      occupancy <= occ_ext[OCC_W-1:0];
    end
  end

`ifndef SYNTH
  a_slot_accounting: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cnt} + {1'b0, fcnt}) == {1'b0, hwm})
    else $error("live plus free slots differ from used slot range");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (out_key == '0 && out_value == '0))
    else $error("error response carries a nonzero entry");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("new word taken while one is in work");

  a_last_key_monotone: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (last_key >= $past(last_key)))
    else $error("last popped key decreased");
`endif

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the monotone radix heap. A model of the bucket
// store predicts each result; the bench sends directed and random push/pop
// words with random idling, back-pressure and a fill to full capacity.
// ----------------------------------------------------------------------------
module testbench;
  import mrh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 1024;
  localparam int NB  = 33;

  typedef struct {
    logic [31:0] k;
    logic [15:0] v;
    status_t     st;
    logic [10:0] occ;
  } heap_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_ready;
  logic        cmd = CMD_PUSH;
  logic [31:0] key = '0;
  logic [15:0] value = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  logic [31:0] out_key;
  logic [15:0] out_value;
  logic [1:0]  status;
  logic [OCC_W-1:0] occupancy;

  // heap shadow state
  logic [31:0] hk [CAP];
  logic [15:0] hv [CAP];
  int          hb [CAP];
  logic [31:0] ho [CAP];
  bit          hvld [CAP];
  int          bcnt [NB];
  logic [31:0] floor_key;
  int          held;
  logic [31:0] stamp;

  heap_rsp_t   pending_q[$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          rsp_hold = 0;

  monotone_radix_heap i_dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .key(key), .value(value),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .out_key(out_key), .out_value(out_value),
    .status(status), .occupancy(occupancy)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int bitlen(logic [31:0] a);
    int n;
    n = 0;
    while (a != 0) begin
      n++;
      a = a >> 1;
    end
    return n;
  endfunction

  function automatic void heap_clear();
    foreach (hvld[i]) hvld[i] = 1'b0;
    foreach (bcnt[i]) bcnt[i] = 0;
    floor_key = '0;
    held = 0;
    stamp = '0;
  endfunction

  // stamps run out: rank live entries by stamp, keeping their order
  function automatic void heap_renumber();
    int rk [CAP];
    foreach (hvld[i]) begin
      rk[i] = 0;
      if (hvld[i]) begin
        foreach (hvld[j]) if (hvld[j] && ho[j] < ho[i]) rk[i]++;
      end
    end
    foreach (hvld[i]) if (hvld[i]) ho[i] = 32'(rk[i]);
    stamp = 32'(held);
  endfunction

  // key at or above the floor, clamped at the top of the key range
  function automatic logic [31:0] above_floor(int span);
    logic [32:0] sum;
    sum = {1'b0, floor_key} + 33'(span);
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic heap_rsp_t heap_apply(logic c, logic [31:0] k, logic [15:0] v);
    heap_rsp_t r;
    int slot, bi, best, nb;
    logic [31:0] mk;
    logic [15:0] mv;
    bit found;
    r.k = '0;
    r.v = '0;
    r.st = ST_OK;
    if (c == CMD_PUSH) begin
      if (held >= CAP) r.st = ST_FULL;
      else if (k < floor_key) r.st = ST_LOW;
      else begin
        slot = 0;
        while (hvld[slot]) slot++;
        if (stamp == 32'hFFFF_FFFF) heap_renumber();
        hk[slot] = k;
        hv[slot] = v;
        hb[slot] = bitlen(k ^ floor_key);
        ho[slot] = stamp;
        hvld[slot] = 1'b1;
        stamp++;
        bcnt[hb[slot]]++;
        held++;
      end
    end else if (held == 0) begin
      r.st = ST_EMPTY;
    end else begin
      if (bcnt[0] == 0) begin
        bi = 1;
        while (bcnt[bi] == 0) bi++;
        found = 1'b0;
        mk = '0;
        mv = '0;
        for (int i = 0; i < CAP; i++) begin
          if (hvld[i] && hb[i] == bi &&
              (!found || hk[i] < mk || (hk[i] == mk && hv[i] < mv))) begin
            mk = hk[i];
            mv = hv[i];
            found = 1'b1;
          end
        end
        floor_key = mk;
        for (int i = 0; i < CAP; i++) begin
          if (hvld[i] && hb[i] == bi) begin
            nb = bitlen(hk[i] ^ floor_key);
            hb[i] = nb;
            bcnt[bi]--;
            bcnt[nb]++;
          end
        end
      end
      best = -1;
      for (int i = 0; i < CAP; i++)
        if (hvld[i] && hb[i] == 0 && (best < 0 || ho[i] > ho[best])) best = i;
      r.k = hk[best];
      r.v = hv[best];
      hvld[best] = 1'b0;
      bcnt[0]--;
      held--;
    end
    r.occ = held[10:0];
    return r;
  endfunction

  task automatic pause_cmd();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_word(logic c, logic [31:0] k, logic [15:0] v);
    pause_cmd();
    cmd_valid <= 1'b1;
    cmd <= c;
    key <= k;
    value <= v;
    do @(posedge clk); while (!cmd_ready);
    pending_q.insert(pending_q.size(), heap_apply(c, k, v));
  endtask

  task automatic push_word(logic [31:0] k, logic [15:0] v);
    send_word(CMD_PUSH, k, v);
  endtask

  task automatic pop_word();
    send_word(CMD_POP, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    heap_rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result word: key %h value %h", out_key, out_value);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_key !== e.k) begin
          $error("out_key exp %h got %h", e.k, out_key); errors++;
        end
        if (out_value !== e.v) begin
          $error("out_value exp %h got %h", e.v, out_value); errors++;
        end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (occupancy !== e.occ) begin
          $error("occupancy exp %0d got %0d", e.occ, occupancy); errors++;
        end
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ready <= 1'b0;
      end else begin
        if (stall == 0 && idle_on && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
        if (stall > 0) begin
          stall--;
          rsp_ready <= 1'b0;
        end else begin
          rsp_ready <= 1'b1;
        end
      end
    end
  end

  task automatic test_directed();
    pop_word();
    push_word(32'd0, 16'h0000);
    pop_word();
    push_word(32'd100, 16'h0001);
    push_word(32'd100, 16'h0000);
    push_word(32'd200, 16'h5555);
    push_word(32'hFFFF_FFFF, 16'hFFFF);
    push_word(32'hAAAA_AAAA, 16'hAAAA);
    pop_word();
    pop_word();
    push_word(32'd50, 16'h1234);
    pop_word();
    push_word(32'h5555_5555, 16'h5555);
    pop_word();
    pop_word();
    pop_word();
    pop_word();
    pop_word();
    wait_drained();
  endtask

  // mostly keys at or above the floor with random spread, some arbitrary keys
  task automatic test_random(int n);
    logic [32:0] sum;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if (held > 0 && $urandom_range(0, 99) < (held > 40 ? 75 : 40)) begin
        pop_word();
      end else begin
        if ($urandom_range(0, 9) == 0) k = $urandom;
        else begin
          sum = {1'b0, floor_key} + ({1'b0, $urandom} & ((33'd1 << $urandom_range(0, 32)) - 1));
          k = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        push_word(k, $urandom);
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    rsp_hold = 400;
    for (int i = 0; i < 40; i++) push_word(above_floor($urandom_range(0, 4096)), $urandom);
    wait_drained();
    for (int i = 0; i < 40; i++) pop_word();
    wait_drained();
  endtask

  // fill to capacity last: every later pop walks all slots
  task automatic test_fill();
    idle_on = 1'b0;
    while (held < CAP) push_word(above_floor($urandom_range(0, 65535)), $urandom);
    push_word(32'hFFFF_FFFF, 16'hFFFF);
    push_word(32'd0, 16'h0000);
    for (int i = 0; i < 12; i++) pop_word();
    push_word(32'd0, 16'h0000);
    push_word(floor_key, 16'h0042);
    pop_word();
    wait_drained();
  endtask

  initial begin
    heap_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(520);
    test_backpressure();
    test_random(20);
    test_fill();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
sv/mrh_pkg.sv
sv/mrh_ram.sv
sv/mrh_cmp.sv
sv/monotone_radix_heap.sv
tb/testbench.sv
